/* sv/ffp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types, frame constants and CRC-8 helpers for the frame parser.
// ----------------------------------------------------------------------------
package ffp_pkg;

   localparam int unsigned WIN_DEPTH = 12;   // longest frame, CRC mode
   localparam int unsigned LEN_PLAIN = 11;   // frame length without CRC
   localparam int unsigned LEN_CRC   = 12;   // frame length with CRC
   localparam int unsigned CRC_SPAN  = 9;    // id plus eight payload bytes

   localparam logic [7:0] START_MARK = 8'hAA;
   localparam logic [7:0] END_MARK   = 8'h55;
   localparam logic [7:0] CRC_POLY   = 8'h07;

   typedef logic [7:0]                          byte_type;
   typedef logic [3:0]                          count_type;
   typedef logic [WIN_DEPTH-1:0][7:0]           window_type;
   typedef logic [CRC_SPAN-1:0][7:0]            crc_span_type;
   typedef logic [CRC_SPAN-1:0][7:0][7:0]       crc_cols_type;

   // Contribution of each message bit to the final CRC (the CRC is linear,
   // init zero). Entry [j][i] is the CRC of a message holding only bit i of
   // byte j. Evaluated once at elaboration.
   function automatic crc_cols_type crc_cols_f();
      crc_cols_type cols;
      logic [7:0]   acc;
      int           j;
      int           i;
      int           s;
      cols = '0;
      for (j = 0; j < CRC_SPAN; j++) begin
         for (i = 0; i < 8; i++) begin
            acc = 8'(1 << i);
            for (s = 0; s < 8 * (CRC_SPAN - j); s++) begin
               if (acc[7]) begin
                  acc = {acc[6:0], 1'b0} ^ CRC_POLY;
               end else begin
                  acc = {acc[6:0], 1'b0};
               end
            end
            cols[4'(j)][3'(i)] = acc;
         end
      end
      return cols;
   endfunction

   localparam crc_cols_type CRC_COLS = crc_cols_f();

endpackage : ffp_pkg
`default_nettype wire

/* sv/ffp_crc8.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_crc8
// CRC-8 (poly 0x07, init 0, MSB first) over nine bytes as one XOR tree.
// ----------------------------------------------------------------------------
module ffp_crc8
   import ffp_pkg::*;
(
   input  wire crc_span_type span_bytes,   // [0] is the first byte sent
   output byte_type          crc_value
);

   // Each set message bit folds in its precomputed column.
   always_comb begin
      crc_value = '0;
      for (int j = 0; j < CRC_SPAN; j++) begin
         for (int i = 0; i < 8; i++) begin
            if (span_bytes[4'(j)][3'(i)]) begin
               crc_value = crc_value ^ CRC_COLS[4'(j)][3'(i)];
            end
         end
      end
   end

endmodule : ffp_crc8
`default_nettype wire

/* sv/fixed_frame_parser_crc8_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_frame_parser_crc8_unit
// Finds 0xAA, id, 8 payload bytes, [CRC-8], 0x55 frames in a byte stream.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          data
//   -------  ---  -----------------  ------------------------------------------
//   req      in   req_valid/ready    req_rx_byte: one received byte
//   rsp      out  rsp_valid/ready    rsp_frame_id, rsp_frame_payload
//   csr      in   csr_wr_en          csr_wr_data: crc_enable (12-byte frames)
//
// One word per cycle sustained. A word waits in the input register, and there
// the window check, CRC tree and window shift run combinationally into the
// window and result registers, so a frame reaches rsp after its 0x55 word
// passes the input and then the result register. req stalls only while a
// finished frame waits on rsp and the input register is full. Synchronous
// reset empties the window, drops both valid flags and clears crc_enable.
// ----------------------------------------------------------------------------
module fixed_frame_parser_crc8_unit
   import ffp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   // byte input
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_rx_byte,
   // frame output
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_frame_id,
   output logic [63:0] rsp_frame_payload,
   // configuration
   input  wire         csr_wr_en,
   input  wire         csr_wr_data
);

   // Input register
   logic       in_vld_ff;
   byte_type   in_byte_ff;

   // Scan window: bytes from the leftmost pending start mark onward
   window_type win_ff;
   count_type  fill_ff;

   // Result register
   logic        out_vld_ff;
   byte_type    out_id_ff;
   logic [63:0] out_pay_ff;

   logic        crc_en_ff;

   // Processing signals
   logic         proc_go;
   window_type   w;
   count_type    n;
   count_type    frame_len;
   crc_span_type span;
   byte_type     crc_calc;
   logic         chk0;
   logic         ok0;
   logic         try1;
   logic         accept0;
   logic         accept1;
   count_type    scan_base;
   count_type    drop_cnt;
   window_type   win_in;
   count_type    fill_in;
   count_type    sel;
   byte_type     id_in;
   logic [63:0]  pay_in;

   // Advance the window when the result slot is free or being emptied.
   assign proc_go   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || proc_go;

   assign rsp_valid         = out_vld_ff;
   assign rsp_frame_id      = out_id_ff;
   assign rsp_frame_payload = out_pay_ff;

   // CRC over id and payload of a candidate at window start
   always_comb begin
      for (int j = 0; j < CRC_SPAN; j++) begin
         span[4'(j)] = w[4'(j + 1)];
      end
   end

   ffp_crc8 u_crc (
      .span_bytes (span),
      .crc_value  (crc_calc)
   );

   always_comb begin
      // append the new word; only a mode switch leaves a full frame held
      w          = win_ff;
      w[fill_ff] = in_byte_ff;
      n          = fill_ff + 4'd1;
      frame_len  = crc_en_ff ? 4'(LEN_CRC) : 4'(LEN_PLAIN);

      // candidate at slot 0 (slot 0 always holds a start mark once filled)
      chk0 = (n >= frame_len);
      ok0  = (w[0] == START_MARK) && (w[frame_len - 4'd1] == END_MARK) &&
             (!crc_en_ff || (crc_calc == w[10]));

      // after a mode switch to plain frames the window can reach twelve
      // bytes: a failed slot 0 then leaves a second candidate at slot 1
      try1    = chk0 && !ok0 && !crc_en_ff && (n == 4'(WIN_DEPTH)) &&
                (w[1] == START_MARK);
      accept0 = chk0 && ok0;
      accept1 = try1 && (w[WIN_DEPTH-1] == END_MARK);

      // first slot that may start the next candidate
      if (accept0) begin
         scan_base = frame_len;
      end else if (accept1) begin
         scan_base = 4'(WIN_DEPTH);
      end else if (try1) begin
         scan_base = 4'd2;
      end else if (chk0) begin
         scan_base = 4'd1;
      end else begin
         scan_base = 4'd0;
      end

      // drop up to the next start mark at or after the base, else empty out
      drop_cnt = n;
      for (int k = WIN_DEPTH - 1; k >= 0; k--) begin
         if ((4'(k) >= scan_base) && (4'(k) < n) && (w[4'(k)] == START_MARK)) begin
            drop_cnt = 4'(k);
         end
      end
      fill_in = n - drop_cnt;
      win_in  = w >> {drop_cnt, 3'b000};

      // frame fields
      sel   = accept1 ? 4'd1 : 4'd0;
      id_in = w[4'd1 + sel];
      for (int k = 0; k < 8; k++) begin
         pay_in[6'(63 - 8*k) -: 8] = w[4'(k + 2) + sel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         fill_ff    <= '0;
         out_vld_ff <= 1'b0;
         crc_en_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            crc_en_ff <= csr_wr_data;
         end

         // hold the word until the window takes it
         if (req_valid && req_ready) begin
            in_vld_ff <= 1'b1;
         end else if (proc_go) begin
            in_vld_ff <= 1'b0;
         end

         if (proc_go) begin
            fill_ff    <= fill_in;
            out_vld_ff <= accept0 || accept1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (proc_go) begin
         win_ff <= win_in;
         if (accept0 || accept1) begin
            out_id_ff  <= id_in;
            out_pay_ff <= pay_in;
         end
      end
   end

endmodule : fixed_frame_parser_crc8_unit
`default_nettype wire

/* test/tb_fixed_frame_parser_crc8_unit.sv */
// ----------------------------------------------------------------------------
// tb_fixed_frame_parser_crc8_unit
// Self-checking bench for the delimited frame parser with optional CRC-8.
// ----------------------------------------------------------------------------
// Bytes go in one word per handshake. Every accepted word also runs through a
// local frame scanner that mirrors the parser's sliding window. Each frame
// that the scanner finds is queued and compared, field by field, with the
// next word taken from the frame output. The run starts with a short directed
// part: leading noise, a failed candidate, extreme ids and payloads, and a
// CRC mode change with a full window. Random phases follow, mostly
// well-formed frames with random content plus broken frames and noise. The
// CRC mode is rewritten only between phases, once the parser has gone idle.
// ----------------------------------------------------------------------------
module tb_fixed_frame_parser_crc8_unit;
   import ffp_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_BYTES   = 100;   // least words per random phase
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned MAX_IDLE      = 11;    // longest gap or stall
   localparam int unsigned PRINT_CAP     = 40;

   typedef enum {FRAME_GOOD, FRAME_BAD_END, FRAME_BAD_CRC, FRAME_CUT} frame_shape_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [63:0] payload;
   } frame_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_frame_id;
   logic [63:0] rsp_frame_payload;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   fixed_frame_parser_crc8_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_id      (rsp_frame_id),
      .rsp_frame_payload (rsp_frame_payload),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // words waiting to be sent, frames the scanner says must come out
   logic [7:0]    byte_stream [$];
   frame_rec_type frames_due [$];
   int unsigned   mismatch_count = 0;

   // scanner state: bytes held from the leftmost pending start marker on
   logic [7:0]  held_bytes [WIN_DEPTH];
   int unsigned held_count = 0;
   bit          crc_on = 1'b0;

   // idle control for both sides
   int unsigned send_gap = 0;
   bit          send_calm = 1'b0;
   int unsigned drain_hold = 0;
   bit          drain_calm = 1'b0;

   // Bit-serial MSB-first CRC-8 over id and payload, init zero.
   function automatic logic [7:0] crc8_of(input logic [7:0] id, input logic [63:0] payload);
      logic [71:0] msg;
      logic [7:0]  acc;
      logic        fb;
      int          i;
      msg = {id, payload};
      acc = 8'h00;
      for (i = 71; i >= 0; i--) begin
         fb  = acc[7] ^ msg[i];
         acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   function automatic void drop_held(input int unsigned n);
      int unsigned k;
      if (n >= held_count) begin
         held_count = 0;
      end else begin
         for (k = 0; k + n < held_count; k++) begin
            held_bytes[k] = held_bytes[k + n];
         end
         held_count = held_count - n;
      end
   endfunction

   // Push one accepted word through the window; queue the first good frame.
   function automatic void scan_byte(input logic [7:0] rx);
      int unsigned   flen;
      int unsigned   k;
      bit            ok;
      bit            done;
      bit            produced;
      logic [63:0]   pay;
      frame_rec_type rec;
      flen     = crc_on ? LEN_CRC : LEN_PLAIN;
      produced = 1'b0;
      done     = 1'b0;
      if (held_count < WIN_DEPTH) begin
         held_bytes[held_count] = rx;
         held_count++;
      end
      while (!done) begin
         // drop leading noise until a start marker heads the window
         while (held_count > 0 && held_bytes[0] != START_MARK) begin
            drop_held(1);
         end
         if (held_count < flen) begin
            done = 1'b1;
         end else begin
            pay = '0;
            for (k = 0; k < 8; k++) begin
               pay = {pay[55:0], held_bytes[2 + k]};
            end
            ok = (held_bytes[flen - 1] == END_MARK);
            if (ok && crc_on) begin
               ok = (crc8_of(held_bytes[1], pay) == held_bytes[10]);
            end
            if (ok) begin
               // only one frame can leave per word; extra ones are consumed
               if (!produced) begin
                  rec.id      = held_bytes[1];
                  rec.payload = pay;
                  frames_due.push_back(rec);
                  produced = 1'b1;
               end
               drop_held(flen);
            end else begin
               drop_held(1);
            end
         end
      end
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 15))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return START_MARK;
         3:       return END_MARK;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_payload();
      logic [63:0] pay;
      int          k;
      case ($urandom_range(0, 7))
         0: pay = '0;
         1: pay = '1;
         2: begin
            // plant markers inside the payload now and then
            for (k = 0; k < 8; k++) begin
               pay = {pay[55:0], pick_byte()};
            end
         end
         default: pay = {$urandom, $urandom};
      endcase
      return pay;
   endfunction

   // Queue one frame in the current CRC mode, well formed or broken.
   function automatic void queue_frame(input frame_shape_type shape, input logic [7:0] id,
                                       input logic [63:0] payload);
      logic [71:0] body;
      logic [7:0]  crc;
      logic [7:0]  tail;
      int unsigned cut;
      int unsigned k;
      body = {id, payload};
      byte_stream.push_back(START_MARK);
      if (shape == FRAME_CUT) begin
         cut = $urandom_range(0, 9);
         for (k = 0; k < cut; k++) begin
            byte_stream.push_back(body[71 - 8 * k -: 8]);
         end
      end else begin
         for (k = 0; k < 9; k++) begin
            byte_stream.push_back(body[71 - 8 * k -: 8]);
         end
         if (crc_on) begin
            crc = crc8_of(id, payload);
            if (shape == FRAME_BAD_CRC) begin
               crc = crc ^ 8'(1 << $urandom_range(0, 7));
            end
            byte_stream.push_back(crc);
         end
         tail = END_MARK;
         if (shape == FRAME_BAD_END) begin
            tail = 8'($urandom);
            if (tail == END_MARK) begin
               tail = tail ^ 8'h01;
            end
         end
         byte_stream.push_back(tail);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_CAP) begin
         $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Byte driver: hold each word until taken, then draw a gap for the next.
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'h00;
         send_gap    = $urandom_range(0, MAX_IDLE);
      end else begin
         if (req_valid && req_ready) begin
            scan_byte(req_rx_byte);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  = send_gap - 1;
               req_valid <= 1'b0;
            end else if (byte_stream.size() != 0) begin
               req_rx_byte <= byte_stream.pop_front();
               req_valid   <= 1'b1;
               // switch between bursty and back-to-back stretches now and then
               if ($urandom_range(0, 39) == 0) begin
                  send_calm = !send_calm;
               end
               send_gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Frame monitor: check each taken word, then stall the next one a while.
   always @(posedge clock) begin : frame_monitor
      frame_rec_type due;
      if (reset) begin
         rsp_ready  <= 1'b0;
         drain_hold = $urandom_range(0, MAX_IDLE);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frames_due.size() == 0) begin
               report_mismatch("frame with none due", {56'h0, rsp_frame_id}, 64'h0);
            end else begin
               due = frames_due.pop_front();
               if (rsp_frame_id !== due.id) begin
                  report_mismatch("frame_id", {56'h0, rsp_frame_id}, {56'h0, due.id});
               end
               if (rsp_frame_payload !== due.payload) begin
                  report_mismatch("frame_payload", rsp_frame_payload, due.payload);
               end
            end
            if ($urandom_range(0, 15) == 0) begin
               drain_calm = !drain_calm;
            end
            drain_hold = drain_calm ? 0 : $urandom_range(0, MAX_IDLE);
         end else if (rsp_valid && drain_hold > 0) begin
            drain_hold = drain_hold - 1;
         end
         rsp_ready <= (drain_hold == 0);
      end
   end

   // Wait until every word is in and every frame is out, then let the
   // pipeline drain words that end no frame.
   task automatic settle();
      while (byte_stream.size() != 0 || req_valid || frames_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_crc_mode(input bit on);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      crc_on      = on;
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned roll;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Plain mode after reset: leading noise, then a start marker whose
      // candidate fails on its end byte, then a frame with zero id and payload.
      byte_stream.push_back(8'h00);
      byte_stream.push_back(8'hFF);
      byte_stream.push_back(START_MARK);
      queue_frame(FRAME_GOOD, 8'h00, 64'h0);
      settle();

      // CRC mode: leave a plain-length frame of all-ones in the window; with
      // only 11 bytes held nothing is checked yet.
      write_crc_mode(1'b1);
      byte_stream.push_back(START_MARK);
      repeat (9) byte_stream.push_back(8'hFF);
      byte_stream.push_back(END_MARK);
      settle();

      // Back to plain mode with the window kept: the next word overfills a
      // plain frame, the held frame goes out and the new start marker stays.
      write_crc_mode(1'b0);
      byte_stream.push_back(START_MARK);
      settle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_crc_mode((phase < 2) ? (phase == 0) : 1'($urandom_range(0, 1)));
         while (byte_stream.size() < PHASE_BYTES) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               queue_frame(FRAME_GOOD, pick_byte(), pick_payload());
            end else if (roll < 70) begin
               queue_frame(FRAME_BAD_END, pick_byte(), pick_payload());
            end else if (roll < 78) begin
               queue_frame(crc_on ? FRAME_BAD_CRC : FRAME_BAD_END, pick_byte(),
                           pick_payload());
            end else if (roll < 86) begin
               queue_frame(FRAME_CUT, pick_byte(), pick_payload());
            end else if (roll < 94) begin
               repeat ($urandom_range(1, 4)) byte_stream.push_back(pick_byte());
            end else begin
               byte_stream.push_back(8'($urandom));
            end
         end
         // the sender holds off here until every frame has come out
         settle();
      end

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
